// ----- sv/gcwf_pkg.sv -----
// ----------------------------------------------------------------------------
// gcwf_pkg
// Shared types and constants for the grid cost wavefront field.
// ----------------------------------------------------------------------------
package gcwf_pkg;

	localparam int MAX_SIDE   = 64;
	localparam int SIDE_BITS  = 7;
	localparam int CELL_BITS  = 12;
	localparam int CELLS      = 4096;
	localparam int COUNT_BITS = CELL_BITS + 1;
	localparam int VALUE_BITS = 22;
	localparam int COST_BITS  = 8;
	localparam int DIR_BITS   = 4;
	localparam int ADD_BITS   = COST_BITS + 1;

	localparam logic [VALUE_BITS-1:0] VAL_MAX  = {VALUE_BITS{1'b1}};
	localparam logic [DIR_BITS-1:0]   DIR_NONE = 4'd8;

	localparam logic [1:0] CFG_SIDE    = 2'd0;
	localparam logic [1:0] CFG_BLOCKED = 2'd1;

	typedef enum logic [1:0] {
		FUNC_LOAD = 2'd0,
		FUNC_MARK = 2'd1,
		FUNC_RUN  = 2'd2,
		FUNC_READ = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_NONE   = 2'd0,
		ST_QUEUED = 2'd1,
		ST_DONE   = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_RD,
		S_MK,
		S_POP,
		S_PW,
		S_PC,
		S_DIV,
		S_NB,
		S_CN,
		S_CA,
		S_CB,
		S_CV
	} state_t;

	typedef struct packed {
		func_t                 func;
		logic [CELL_BITS-1:0]  cell_index;
		logic [COST_BITS-1:0]  cell_cost;
	} cmd_t;

	typedef struct packed {
		logic                  result_kind;
		logic [VALUE_BITS-1:0] cell_value;
		logic [DIR_BITS-1:0]   parent_direction;
	} result_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [DIR_BITS-1:0]   dir;
		status_t               status;
	} cell_word_t;

	typedef struct packed {
		logic                  cost_we;
		logic [CELL_BITS-1:0]  cost_waddr;
		logic [COST_BITS-1:0]  cost_wdata;
		logic [CELL_BITS-1:0]  cost_raddr;
		logic                  cell_we;
		logic [CELL_BITS-1:0]  cell_waddr;
		cell_word_t            cell_wdata;
		logic [CELL_BITS-1:0]  cell_raddr;
		logic                  q_we;
		logic [CELL_BITS-1:0]  q_waddr;
		logic [CELL_BITS-1:0]  q_wdata;
		logic [CELL_BITS-1:0]  q_raddr;
	} mem_req_t;

	function automatic logic [DIR_BITS-1:0] opposite(input logic [2:0] k);
		logic [DIR_BITS-1:0] r;
		case (k)
			3'd0: r = 4'd2;
			3'd1: r = 4'd3;
			3'd2: r = 4'd0;
			3'd3: r = 4'd1;
			3'd4: r = 4'd6;
			3'd5: r = 4'd7;
			3'd6: r = 4'd4;
			default: r = 4'd5;
		endcase
		return r;
	endfunction

endpackage

// ----- sv/gcwf_store.sv -----
// ----------------------------------------------------------------------------
// gcwf_store
// Cost, cell and queue memories, one write and one registered read each.
// ----------------------------------------------------------------------------
module gcwf_store import gcwf_pkg::*; (
	input  logic                 clk,
	input  mem_req_t             req,
	output logic [COST_BITS-1:0] cost_rdata,
	output cell_word_t           cell_rdata,
	output logic [CELL_BITS-1:0] q_rdata
);

	logic [COST_BITS-1:0] cost_mem [CELLS];
	cell_word_t           cell_mem [CELLS];
	logic [CELL_BITS-1:0] q_mem    [CELLS];

	always_ff @(posedge clk) begin
		if (req.cost_we) begin
			cost_mem[req.cost_waddr] <= req.cost_wdata;
		end
		cost_rdata <= cost_mem[req.cost_raddr];
	end

	always_ff @(posedge clk) begin
		if (req.cell_we) begin
			cell_mem[req.cell_waddr] <= req.cell_wdata;
		end
		cell_rdata <= cell_mem[req.cell_raddr];
	end

	always_ff @(posedge clk) begin
		if (req.q_we) begin
			q_mem[req.q_waddr] <= req.q_wdata;
		end
		q_rdata <= q_mem[req.q_raddr];
	end

endmodule

// ----- sv/gcwf_div.sv -----
// ----------------------------------------------------------------------------
// gcwf_div
// Restoring divider that splits a cell index into row and column.
// ----------------------------------------------------------------------------
module gcwf_div import gcwf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [CELL_BITS-1:0] dividend,
	input  logic [SIDE_BITS-1:0] divisor,
	output logic [CELL_BITS-1:0] quotient,
	output logic [SIDE_BITS-1:0] remainder,
	output logic                 done
);

	localparam int CNT_BITS = $clog2(CELL_BITS + 1);

	logic [CNT_BITS-1:0]  cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [CELL_BITS-1:0] quo_q;
	logic [SIDE_BITS-1:0] rem_q;
	logic [SIDE_BITS-1:0] dvs_q;
	logic [SIDE_BITS:0]   trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[CELL_BITS-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_BITS'(CELL_BITS - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? SIDE_BITS'(trial - {1'b0, dvs_q}) : trial[SIDE_BITS-1:0];
			quo_q <= {quo_q[CELL_BITS-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

// ----- sv/grid_cost_wavefront_field_top.sv -----
// ----------------------------------------------------------------------------
// grid_cost_wavefront_field_top
// Eight-neighbor FIFO label-correcting distance field over a cost grid.
// ----------------------------------------------------------------------------
// After reset the block clears its whole cell memory with busy high.
// A load is written from the idle state; a mark passes through S_MK and a read
// through S_RD, whose result is registered onto the strobe. A run pops one cell
// at a time: S_POP, S_PW and S_PC fetch the cell, the bit-serial divider in
// S_DIV splits its index, then S_NB, S_CN, S_CA, S_CB and S_CV check each
// neighbor on the single cost read port and the cell memory.
// Configuration writes are taken only while the block is idle.
// Results cannot be held off by the receiver; each is valid for one cycle.
module grid_cost_wavefront_field_top import gcwf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  cmd_t                 cmd,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [COST_BITS-1:0] cfg_data,
	output logic                 result_valid,
	output result_t              result
);

	state_t state_q, state_d;
	mem_req_t req;
	logic [COST_BITS-1:0] cost_rdata;
	cell_word_t cell_rdata;
	logic [CELL_BITS-1:0] q_rdata;

	logic [SIDE_BITS-1:0] side_q, eff_side;
	logic [COST_BITS-1:0] blk_q;
	logic [COUNT_BITS-1:0] ncell;
	logic [CELL_BITS-1:0] head_q, clr_q, c_q, n_q, a_q, b_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [2:0] k_q;
	logic stale_q, rd_in_q;
	logic [VALUE_BITS-1:0] cv_q;
	logic [SIDE_BITS-1:0] cx_q, cy_q;
	logic [COST_BITS-1:0] ac_q;
	logic [ADD_BITS-1:0] add_q, diag_add;
	logic out_valid_q;
	result_t out_q;

	logic accept, in_grid, adv, push, pop, div_start, div_done, nb_ok, improve;
	logic [CELL_BITS-1:0] div_quo;
	logic [SIDE_BITS-1:0] div_rem;
	logic xp, xm, yp, ym;
	logic [CELL_BITS-1:0] a_addr, b_addr, n_addr, push_idx;
	logic [VALUE_BITS:0] nv_wide;
	logic [VALUE_BITS-1:0] nv;

	gcwf_store u_store (
		.clk        (clk),
		.req        (req),
		.cost_rdata (cost_rdata),
		.cell_rdata (cell_rdata),
		.q_rdata    (q_rdata)
	);

	gcwf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (q_rdata),
		.divisor   (eff_side),
		.quotient  (div_quo),
		.remainder (div_rem),
		.done      (div_done)
	);

	assign eff_side = (side_q == '0) ? SIDE_BITS'(1) :
		(side_q > SIDE_BITS'(MAX_SIDE)) ? SIDE_BITS'(MAX_SIDE) : side_q;
	assign ncell     = COUNT_BITS'(eff_side) * COUNT_BITS'(eff_side);
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign accept    = start && !busy;
	assign in_grid   = {1'b0, cmd.cell_index} < ncell;

	always_comb begin
		xp = 1'b0;
		xm = 1'b0;
		yp = 1'b0;
		ym = 1'b0;
		case (k_q)
			3'd0: ym = 1'b1;
			3'd1: xp = 1'b1;
			3'd2: yp = 1'b1;
			3'd3: xm = 1'b1;
			3'd4: begin xp = 1'b1; ym = 1'b1; end
			3'd5: begin xp = 1'b1; yp = 1'b1; end
			3'd6: begin xm = 1'b1; yp = 1'b1; end
			default: begin xm = 1'b1; ym = 1'b1; end
		endcase
	end

	assign nb_ok = !(xp && ({1'b0, cx_q} + 8'd1 >= {1'b0, eff_side})) &&
		!(xm && (cx_q == '0)) &&
		!(yp && ({1'b0, cy_q} + 8'd1 >= {1'b0, eff_side})) &&
		!(ym && (cy_q == '0));
	assign a_addr = xp ? c_q + 1'b1 : (xm ? c_q - 1'b1 : c_q);
	assign b_addr = yp ? c_q + CELL_BITS'(eff_side) :
		(ym ? c_q - CELL_BITS'(eff_side) : c_q);
	assign n_addr = yp ? a_addr + CELL_BITS'(eff_side) :
		(ym ? a_addr - CELL_BITS'(eff_side) : a_addr);

	assign diag_add = add_q + ADD_BITS'(({1'b0, ac_q} + {1'b0, cost_rdata}) >> 2);
	assign nv_wide  = {1'b0, cv_q} + (VALUE_BITS + 1)'(add_q);
	assign nv       = (nv_wide > {1'b0, VAL_MAX}) ? VAL_MAX : nv_wide[VALUE_BITS-1:0];
	assign improve  = nv < cell_rdata.value;
	assign push_idx = head_q + count_q[CELL_BITS-1:0];

	always_comb begin
		state_d   = state_q;
		req       = '0;
		adv       = 1'b0;
		push      = 1'b0;
		pop       = 1'b0;
		div_start = 1'b0;
		req.q_waddr = push_idx;
		case (state_q)
			S_CLR: begin
				req.cell_we    = 1'b1;
				req.cell_waddr = clr_q;
				req.cell_wdata = '{value: VAL_MAX, dir: DIR_NONE, status: ST_NONE};
				if (clr_q == CELL_BITS'(CELLS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req.cell_raddr = cmd.cell_index;
				if (accept) begin
					case (cmd.func)
						FUNC_LOAD: begin
							req.cost_we    = in_grid;
							req.cost_waddr = cmd.cell_index;
							req.cost_wdata = cmd.cell_cost;
						end
						FUNC_MARK: if (in_grid) state_d = S_MK;
						FUNC_RUN:  state_d = S_POP;
						default:   state_d = S_RD;
					endcase
				end
			end
			S_RD: state_d = S_IDLE;
			S_MK: begin
				req.cell_we    = 1'b1;
				req.cell_waddr = c_q;
				req.cell_wdata = '{value: '0, dir: DIR_NONE, status: ST_QUEUED};
				push           = (cell_rdata.status != ST_QUEUED);
				req.q_we       = push;
				req.q_wdata    = c_q;
				state_d        = S_IDLE;
			end
			S_POP: begin
				req.q_raddr = head_q;
				if (count_q == '0) begin
					state_d = S_IDLE;
				end else begin
					pop     = 1'b1;
					state_d = S_PW;
				end
			end
			S_PW: begin
				req.cell_raddr = q_rdata;
				div_start      = 1'b1;
				state_d        = S_PC;
			end
			S_PC: begin
				req.cell_we    = 1'b1;
				req.cell_waddr = c_q;
				req.cell_wdata = '{value: cell_rdata.value, dir: cell_rdata.dir,
					status: ST_DONE};
				state_d        = stale_q ? S_POP : S_DIV;
			end
			S_DIV: if (div_done) state_d = S_NB;
			S_NB: begin
				req.cost_raddr = n_addr;
				if (nb_ok) state_d = S_CN;
				else adv = 1'b1;
			end
			S_CN: begin
				req.cost_raddr = a_q;
				req.cell_raddr = n_q;
				if (cost_rdata == blk_q) adv = 1'b1;
				else state_d = k_q[2] ? S_CA : S_CV;
			end
			S_CA: begin
				req.cost_raddr = b_q;
				if (cost_rdata == blk_q) adv = 1'b1;
				else state_d = S_CB;
			end
			S_CB: begin
				req.cell_raddr = n_q;
				if (cost_rdata == blk_q) adv = 1'b1;
				else state_d = S_CV;
			end
			S_CV: begin
				adv            = 1'b1;
				req.cell_we    = improve;
				req.cell_waddr = n_q;
				req.cell_wdata = '{value: nv, dir: opposite(k_q), status: ST_QUEUED};
				push           = improve && (cell_rdata.status != ST_QUEUED);
				req.q_we       = push;
				req.q_wdata    = n_q;
			end
			default: state_d = S_IDLE;
		endcase
		if (adv) begin
			state_d = (k_q == 3'd7) ? S_POP : S_NB;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			side_q      <= SIDE_BITS'(MAX_SIDE);
			blk_q       <= '1;
			head_q      <= '0;
			count_q     <= '0;
			clr_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SIDE:    side_q <= cfg_data[SIDE_BITS-1:0];
					CFG_BLOCKED: blk_q  <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_CLR) clr_q <= clr_q + 1'b1;
			if (pop) begin
				head_q  <= head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end else if (push) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == S_DIV) k_q <= '0;
			else if (adv) k_q <= k_q + 1'b1;
			out_valid_q <= (state_q == S_RD) || (state_q == S_POP && count_q == '0);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				c_q     <= cmd.cell_index;
				rd_in_q <= in_grid;
			end
			S_RD: begin
				out_q.result_kind      <= 1'b1;
				out_q.cell_value       <= rd_in_q ? cell_rdata.value : VAL_MAX;
				out_q.parent_direction <= rd_in_q ? cell_rdata.dir : DIR_NONE;
			end
			S_POP: begin
				out_q.result_kind      <= 1'b0;
				out_q.cell_value       <= '0;
				out_q.parent_direction <= DIR_NONE;
			end
			S_PW: begin
				c_q     <= q_rdata;
				stale_q <= {1'b0, q_rdata} >= ncell;
			end
			S_PC: cv_q <= cell_rdata.value;
			S_DIV: begin
				cx_q <= div_rem;
				cy_q <= div_quo[SIDE_BITS-1:0];
			end
			S_NB: begin
				n_q <= n_addr;
				a_q <= a_addr;
				b_q <= b_addr;
			end
			S_CN: add_q <= ADD_BITS'(cost_rdata);
			S_CA: ac_q <= cost_rdata;
			S_CB: add_q <= diag_add;
			default: ;
		endcase
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_BITS'(CELLS))
		else $error("queue count exceeds the grid size");

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result strobe without a command in progress");

	a_run_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.func == FUNC_RUN) |=> busy)
		else $error("run transaction did not start the wavefront");

	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && pop))
		else $error("queue push and pop in the same cycle");

endmodule

// ----- tb/tb_grid_cost_wavefront_field_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_cost_wavefront_field_top
// Self-checking testbench for the grid cost wavefront field.
// Commands are driven with random gaps while an in-bench model of the grid
// predicts every run and read transaction, and a scoreboard compares each
// result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_grid_cost_wavefront_field_top;
	import gcwf_pkg::*;

	class field_scoreboard;
		result_t pending [16];
		int unsigned rd_ptr;
		int unsigned wr_ptr;
		int errors;

		function int unsigned outstanding();
			return wr_ptr - rd_ptr;
		endfunction

		function void note(result_t r);
			pending[wr_ptr % 16] = r;
			wr_ptr++;
		endfunction

		function void check(result_t got);
			result_t want;
			if (outstanding() == 0) begin
				$display("%0t unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = pending[rd_ptr % 16];
			rd_ptr++;
			if (got.result_kind !== want.result_kind) begin
				$display("%0t kind expected %0d actual %0d", $time,
					want.result_kind, got.result_kind);
				errors++;
			end
			if (got.cell_value !== want.cell_value) begin
				$display("%0t value expected %0d actual %0d", $time,
					want.cell_value, got.cell_value);
				errors++;
			end
			if (got.parent_direction !== want.parent_direction) begin
				$display("%0t direction expected %0d actual %0d", $time,
					want.parent_direction, got.parent_direction);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, cfg_valid, cfg_ready, result_valid;
	cmd_t cmd;
	logic [1:0] cfg_index;
	logic [COST_BITS-1:0] cfg_data;
	result_t result;

	grid_cost_wavefront_field_top DUT (.*);

	field_scoreboard sb;
	int unsigned m_side, m_blocked;
	logic [COST_BITS-1:0] m_cost [CELLS];
	logic [VALUE_BITS-1:0] m_value [CELLS];
	logic [DIR_BITS-1:0] m_dir [CELLS];
	status_t m_status [CELLS];
	int unsigned wave_mem [CELLS];
	int unsigned wave_head, wave_count;
	int idle_cycles;
	bit calm;
	int unsigned cur_side;

	localparam int DX [8] = '{0, 1, 0, -1, 1, 1, -1, -1};
	localparam int DY [8] = '{-1, 0, 1, 0, -1, 1, 1, -1};
	localparam logic [3:0] OPP [8] = '{2, 3, 0, 1, 6, 7, 4, 5};

	function automatic int unsigned grid_side();
		if (m_side == 0) return 1;
		if (m_side > MAX_SIDE) return MAX_SIDE;
		return m_side;
	endfunction

	function automatic void enqueue_cell(int unsigned idx);
		if (wave_count >= CELLS) return;
		wave_mem[(wave_head + wave_count) % CELLS] = idx;
		wave_count++;
	endfunction

	function automatic void propagate();
		int unsigned s, c, n, a, b, nc;
		int cx, cy, nx, ny;
		longint unsigned nv;
		s = grid_side();
		while (wave_count > 0) begin
			c = wave_mem[wave_head];
			wave_head = (wave_head + 1) % CELLS;
			wave_count--;
			m_status[c] = ST_DONE;
			if (c >= s * s) continue;
			cx = c % s;
			cy = c / s;
			for (int k = 0; k < 8; k++) begin
				nx = cx + DX[k];
				ny = cy + DY[k];
				if (nx < 0 || ny < 0 || nx >= s || ny >= s) continue;
				n = nx + ny * s;
				nc = m_cost[n];
				if (nc == m_blocked) continue;
				nv = m_value[c] + nc;
				if (k >= 4) begin
					a = m_cost[nx + cy * s];
					b = m_cost[cx + ny * s];
					if (a == m_blocked || b == m_blocked) continue;
					nv += (a + b) / 4;
				end
				if (nv > VAL_MAX) nv = VAL_MAX;
				if (nv < m_value[n]) begin
					m_value[n] = VALUE_BITS'(nv);
					m_dir[n] = OPP[k];
					if (m_status[n] != ST_QUEUED) begin
						m_status[n] = ST_QUEUED;
						enqueue_cell(n);
					end
				end
			end
		end
	endfunction

	function automatic void predict(cmd_t c);
		int unsigned s;
		bit in_grid;
		result_t r;
		s = grid_side();
		in_grid = c.cell_index < s * s;
		case (c.func)
			FUNC_LOAD: if (in_grid) m_cost[c.cell_index] = c.cell_cost;
			FUNC_MARK: if (in_grid) begin
				m_value[c.cell_index] = '0;
				m_dir[c.cell_index] = DIR_NONE;
				if (m_status[c.cell_index] != ST_QUEUED) begin
					m_status[c.cell_index] = ST_QUEUED;
					enqueue_cell(c.cell_index);
				end
			end
			FUNC_RUN: begin
				propagate();
				r = '{1'b0, '0, DIR_NONE};
				sb.note(r);
			end
			default: begin
				r.result_kind = 1'b1;
				r.cell_value = in_grid ? m_value[c.cell_index] : VAL_MAX;
				r.parent_direction = in_grid ? m_dir[c.cell_index] : DIR_NONE;
				sb.note(r);
			end
		endcase
	endfunction

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (result_valid) sb.check(result);
		if (start && !busy || cfg_valid && cfg_ready || result_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 400000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic gap();
		if (!calm && $urandom_range(3) == 0) repeat ($urandom_range(12, 1)) @(negedge clk);
	endtask

	task automatic send(func_t f, int unsigned idx, int unsigned cost);
		gap();
		cmd.func = f;
		cmd.cell_index = CELL_BITS'(idx);
		cmd.cell_cost = COST_BITS'(cost);
		start = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict(cmd);
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic settle();
		while (sb.outstanding() > 0) @(negedge clk);
		repeat (20) @(negedge clk);
		while (busy) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int unsigned val);
		settle();
		cfg_index <= idx;
		cfg_data <= COST_BITS'(val);
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_SIDE) m_side = val & 8'h7f;
		else m_blocked = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_grid(int unsigned s, int unsigned block_pct);
		for (int unsigned i = 0; i < s * s; i++)
			send(FUNC_LOAD, i, ($urandom_range(99) < block_pct) ? m_blocked :
				$urandom_range(255));
	endtask

	initial begin
		sb = new();
		start = 0; cmd = '0; cfg_valid = 0; cfg_index = CFG_SIDE; cfg_data = '0;
		arst_n = 0; idle_cycles = 0; calm = 0;
		m_side = 64; m_blocked = 255;
		wave_head = 0; wave_count = 0;
		for (int i = 0; i < CELLS; i++) begin
			m_cost[i] = '0; m_value[i] = VAL_MAX; m_dir[i] = DIR_NONE;
			m_status[i] = ST_NONE; wave_mem[i] = 0;
		end
		repeat (12) @(negedge clk);
		arst_n = 1;

		// Directed: tiny grids, side extremes, out-of-grid, duplicate and
		// blocked targets, and saturation-free corner checks.
		write_reg(CFG_SIDE, 1);
		write_reg(CFG_BLOCKED, 0);
		send(FUNC_LOAD, 0, 0);
		send(FUNC_LOAD, 4095, 7);
		send(FUNC_MARK, 0, 0);
		send(FUNC_MARK, 0, 0);
		send(FUNC_MARK, 4095, 0);
		send(FUNC_RUN, 0, 0);
		send(FUNC_READ, 0, 0);
		send(FUNC_READ, 4095, 0);
		write_reg(CFG_SIDE, 3);
		write_reg(CFG_BLOCKED, 255);
		for (int i = 0; i < 9; i++) send(FUNC_LOAD, i, i == 4 ? 255 : 8'hff - i);
		send(FUNC_MARK, 4, 0);
		send(FUNC_RUN, 0, 0);
		for (int i = 0; i < 9; i++) send(FUNC_READ, i, 0);
		send(FUNC_READ, 9, 0);
		write_reg(CFG_SIDE, 0);
		send(FUNC_READ, 0, 0);
		send(FUNC_RUN, 0, 0);

		// Random phases on grids that mostly stay small.
		for (int ph = 0; ph < 14; ph++) begin
			calm = (ph >= 11);
			write_reg(CFG_SIDE, ph == 5 ? 127 : (ph == 9 ? 64 : $urandom_range(8, 2)));
			write_reg(CFG_BLOCKED, $urandom_range(1) ? 255 : $urandom_range(255));
			cur_side = grid_side();
			if (cur_side > 8) begin
				// The last cell is walled in so the run never reaches unloaded cells.
				for (int i = 0; i < 20; i++) send(FUNC_LOAD, i, $urandom_range(255));
				send(FUNC_LOAD, cur_side * cur_side - 2, m_blocked);
				send(FUNC_LOAD, cur_side * cur_side - 1 - cur_side, m_blocked);
				send(FUNC_LOAD, cur_side * cur_side - 2 - cur_side, m_blocked);
				send(FUNC_MARK, 4095, 0);
				send(FUNC_RUN, 0, 0);
				send(FUNC_READ, 4095, 0);
				send(FUNC_READ, $urandom_range(4095), 0);
				continue;
			end
			load_grid(cur_side, 15);
			repeat ($urandom_range(3, 1))
				send(FUNC_MARK, $urandom_range(cur_side * cur_side - 1), 0);
			if ($urandom_range(3) == 0) send(FUNC_MARK, $urandom_range(4095), 0);
			send(FUNC_RUN, 0, 0);
			for (int i = 0; i < cur_side * cur_side; i++) send(FUNC_READ, i, 0);
			repeat (10) send(func_t'($urandom_range(3)), $urandom_range(4095),
				$urandom_range(255));
			send(FUNC_RUN, 0, 0);
		end
		settle();
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
